// ----- sv/anisotropic_stress_from_strain_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stress-from-strain unit
// Each macro expects clk in scope, and ASFS_ASSERT also rst_n, at the point of use.
// ----------------------------------------------------------------------------
`ifndef ANISOTROPIC_STRESS_FROM_STRAIN_UNIT_MACROS_SVH
`define ANISOTROPIC_STRESS_FROM_STRAIN_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/asfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_pkg
// Shared widths, codes, slot map and stage-enable struct for the unit.
// ----------------------------------------------------------------------------
package asfs_pkg;

  localparam int DATA_W         = 32;
  localparam int POINT_W        = 7;
  localparam int SLOT_W         = 5;
  localparam int NUM_SLOTS      = 21;
  localparam int NUM_ROWS       = 6;
  localparam int FRAC_BITS      = 24;
  localparam int NUM_POINTS_DEF = 128;

  // product of two 32-bit words, sum of two products, sum of six products
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_t;

  typedef logic signed [DATA_W-1:0] word_t;

  // load enables for the three lane stages
  typedef struct packed {
    logic mul;
    logic pair;
    logic sum;
  } lane_en_t;

  // upper-triangle slot of C(row, col), symmetric
  localparam logic [SLOT_W-1:0] SLOT_OF [NUM_ROWS][NUM_ROWS] = '{
    '{5'd0, 5'd1,  5'd2,  5'd3,  5'd4,  5'd5},
    '{5'd1, 5'd6,  5'd7,  5'd8,  5'd9,  5'd10},
    '{5'd2, 5'd7,  5'd11, 5'd12, 5'd13, 5'd14},
    '{5'd3, 5'd8,  5'd12, 5'd15, 5'd16, 5'd17},
    '{5'd4, 5'd9,  5'd13, 5'd16, 5'd18, 5'd19},
    '{5'd5, 5'd10, 5'd14, 5'd17, 5'd19, 5'd20}
  };

endpackage

// ----- sv/asfs_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_bank
// Coefficient store: one memory per slot, NUM_POINTS deep, so that all
// coefficients of a point come out together with registered read data.
// ----------------------------------------------------------------------------
module asfs_bank #(
  parameter int NUM_POINTS = asfs_pkg::NUM_POINTS_DEF,
  parameter int AW         = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [asfs_pkg::SLOT_W-1:0]    wr_slot,
  input  logic [AW-1:0]                  wr_addr,
  input  asfs_pkg::word_t                wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output asfs_pkg::word_t                rd_data [asfs_pkg::NUM_SLOTS]
);

  for (genvar s = 0; s < asfs_pkg::NUM_SLOTS; s++) begin : g_slot
    asfs_pkg::word_t mem [NUM_POINTS];
    asfs_pkg::word_t rd_q_r;

    // slots beyond the last match no memory and drop
    always_ff @(posedge clk) begin
      if (wr_en && (wr_slot == asfs_pkg::SLOT_W'(s))) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_q_r <= mem[rd_addr];
      end
    end

    assign rd_data[s] = rd_q_r;
  end

endmodule

// ----- sv/asfs_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_lane
// One stress row: six coefficient-strain products, a pairwise sum and the
// full-width row total, each stage registered.
// ----------------------------------------------------------------------------
module asfs_lane (
  input  logic                                clk,
  input  asfs_pkg::lane_en_t                  en,
  input  asfs_pkg::word_t                     coeff  [asfs_pkg::NUM_ROWS],
  input  asfs_pkg::word_t                     strain [asfs_pkg::NUM_ROWS],
  output logic signed [asfs_pkg::SUM_W-1:0]   row_sum
);

  logic signed [asfs_pkg::PROD_W-1:0] prod_r [asfs_pkg::NUM_ROWS];
  logic signed [asfs_pkg::PAIR_W-1:0] pair_r [asfs_pkg::NUM_ROWS/2];
  logic signed [asfs_pkg::SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int j = 0; j < asfs_pkg::NUM_ROWS; j++) begin
        prod_r[j] <= coeff[j] * strain[j];
      end
    end
    if (en.pair) begin
      for (int k = 0; k < asfs_pkg::NUM_ROWS / 2; k++) begin
        pair_r[k] <= asfs_pkg::PAIR_W'(prod_r[2*k]) + asfs_pkg::PAIR_W'(prod_r[2*k+1]);
      end
    end
    if (en.sum) begin
      sum_r <= asfs_pkg::SUM_W'(pair_r[0]) + asfs_pkg::SUM_W'(pair_r[1])
             + asfs_pkg::SUM_W'(pair_r[2]);
    end
  end

  assign row_sum = sum_r;

endmodule

// ----- sv/asfs_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_merge
// Output stage: scale each row total, clip to 32 bits, merge the clip flags
// of all lanes and hold the result beat until taken.
// ----------------------------------------------------------------------------
`include "anisotropic_stress_from_strain_unit_macros.svh"

module asfs_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [asfs_pkg::SUM_W-1:0]   row_sum [asfs_pkg::NUM_ROWS],
  output logic                                out_vld,
  output asfs_pkg::word_t                     stress  [asfs_pkg::NUM_ROWS],
  output logic                                sat
);

  localparam int HI_W = asfs_pkg::SUM_W - asfs_pkg::DATA_W + 1;
  localparam asfs_pkg::word_t WORD_MAX = {1'b0, {(asfs_pkg::DATA_W-1){1'b1}}};
  localparam asfs_pkg::word_t WORD_MIN = {1'b1, {(asfs_pkg::DATA_W-1){1'b0}}};

  logic signed [asfs_pkg::SUM_W-1:0] scaled [asfs_pkg::NUM_ROWS];
  asfs_pkg::word_t                   clip   [asfs_pkg::NUM_ROWS];
  logic [asfs_pkg::NUM_ROWS-1:0]     ovf;

  logic                              out_vld_r;
  asfs_pkg::word_t                   stress_r [asfs_pkg::NUM_ROWS];
  logic                              sat_r;
  logic [asfs_pkg::NUM_ROWS-1:0]     at_rail;

  always_comb begin
    for (int i = 0; i < asfs_pkg::NUM_ROWS; i++) begin
      // floor shift, then every bit above the word must copy the sign
      scaled[i] = row_sum[i] >>> asfs_pkg::FRAC_BITS;
      ovf[i]    = (scaled[i][asfs_pkg::SUM_W-1:asfs_pkg::DATA_W-1] != {HI_W{1'b0}})
               && (scaled[i][asfs_pkg::SUM_W-1:asfs_pkg::DATA_W-1] != {HI_W{1'b1}});
      if (!ovf[i]) begin
        clip[i] = scaled[i][asfs_pkg::DATA_W-1:0];
      end else if (scaled[i][asfs_pkg::SUM_W-1]) begin
        clip[i] = WORD_MIN;
      end else begin
        clip[i] = WORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stress_r <= clip;
      sat_r    <= |ovf;
    end
  end

  assign out_vld = out_vld_r;
  assign stress  = stress_r;
  assign sat     = sat_r;

  always_comb begin
    for (int i = 0; i < asfs_pkg::NUM_ROWS; i++) begin
      at_rail[i] = (stress_r[i] == WORD_MAX) || (stress_r[i] == WORD_MIN);
    end
  end

  `ASFS_ASSERT(a_sat_clipped, (out_vld_r && sat_r) |-> |at_rail, "clip flag set with no clipped stress")

endmodule

// ----- sv/anisotropic_stress_from_strain_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anisotropic_stress_from_strain_unit
// Voigt-notation Hooke's law with a symmetric 6x6 stiffness per grid point.
//
//   channel | direction | beat
//   in_     | in        | load one coefficient, or compute a point's stresses
//   out_    | out       | six saturated stresses and a clip flag per compute
//
// One beat a cycle in, one result a cycle out while out_ready holds; the
// accepting edge loads the bank read, followed by the multiply, pair sum,
// row sum and clip registers, the last of which drives out_valid.
// The rate comes from the 21 slot banks read together and 36 multipliers.
// Reset clears the stage valid bits only; the banks are not cleared, so a
// point's coefficients must be loaded before it is computed.
// A stalled output fills the stages in turn; in_ready drops once every stage holds.
// ----------------------------------------------------------------------------
`include "anisotropic_stress_from_strain_unit_macros.svh"

module anisotropic_stress_from_strain_unit #(
  parameter int NUM_POINTS = asfs_pkg::NUM_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [asfs_pkg::POINT_W-1:0]      in_point,
  input  logic [asfs_pkg::SLOT_W-1:0]       in_coeff_slot,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_coeff_value,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_1,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_2,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_3,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_4,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_5,
  input  logic signed [asfs_pkg::DATA_W-1:0] in_strain_voigt_6,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_1,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_2,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_3,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_4,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_5,
  output logic signed [asfs_pkg::DATA_W-1:0] out_stress_voigt_6,
  output logic                              out_saturated
);

  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  logic            in_range;
  logic            in_fire;
  logic            is_compute;
  logic            rd_fire;
  logic            pipe_full;
  logic [AW-1:0]   addr;

  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic v1_r, v2_r, v3_r, v4_r;

  asfs_pkg::word_t   strain_in [asfs_pkg::NUM_ROWS];
  asfs_pkg::word_t   strain_r  [asfs_pkg::NUM_ROWS];
  asfs_pkg::word_t   coef      [asfs_pkg::NUM_SLOTS];
  asfs_pkg::word_t   lane_coef [asfs_pkg::NUM_ROWS][asfs_pkg::NUM_ROWS];
  asfs_pkg::lane_en_t lane_en;
  logic signed [asfs_pkg::SUM_W-1:0] row_sum [asfs_pkg::NUM_ROWS];
  asfs_pkg::word_t   stress [asfs_pkg::NUM_ROWS];

  assign in_range   = (32'(in_point) < NUM_POINTS);
  assign addr       = AW'(in_point);
  assign in_fire    = in_valid && in_ready;
  assign is_compute = (in_action == asfs_pkg::ACT_COMPUTE);
  assign rd_fire    = in_fire && is_compute && in_range;
  assign pipe_full  = v1_r && v2_r && v3_r && v4_r && out_valid;

  // each stage may load when empty or when the next one takes its beat
  assign rdy_out  = !out_valid || out_ready;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign lane_en = '{mul: rdy2, pair: rdy3, sum: rdy4};

  assign strain_in[0] = in_strain_voigt_1;
  assign strain_in[1] = in_strain_voigt_2;
  assign strain_in[2] = in_strain_voigt_3;
  assign strain_in[3] = in_strain_voigt_4;
  assign strain_in[4] = in_strain_voigt_5;
  assign strain_in[5] = in_strain_voigt_6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid && is_compute && in_range;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      strain_r <= strain_in;
    end
  end

  asfs_bank #(
    .NUM_POINTS (NUM_POINTS),
    .AW         (AW)
  ) u_bank (
    .clk     (clk),
    .wr_en   (in_fire && !is_compute && in_range),
    .wr_slot (in_coeff_slot),
    .wr_addr (addr),
    .wr_data (in_coeff_value),
    .rd_en   (rd_fire),
    .rd_addr (addr),
    .rd_data (coef)
  );

  for (genvar r = 0; r < asfs_pkg::NUM_ROWS; r++) begin : g_lane
    for (genvar c = 0; c < asfs_pkg::NUM_ROWS; c++) begin : g_col
      assign lane_coef[r][c] = coef[asfs_pkg::SLOT_OF[r][c]];
    end

    asfs_lane u_lane (
      .clk     (clk),
      .en      (lane_en),
      .coeff   (lane_coef[r]),
      .strain  (strain_r),
      .row_sum (row_sum[r])
    );
  end

  asfs_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (rdy_out),
    .in_vld  (v4_r),
    .row_sum (row_sum),
    .out_vld (out_valid),
    .stress  (stress),
    .sat     (out_saturated)
  );

  assign out_stress_voigt_1 = stress[0];
  assign out_stress_voigt_2 = stress[1];
  assign out_stress_voigt_3 = stress[2];
  assign out_stress_voigt_4 = stress[3];
  assign out_stress_voigt_5 = stress[4];
  assign out_stress_voigt_6 = stress[5];

  `ASFS_ASSERT(a_ready_hold, !in_ready |-> pipe_full, "input stalled with a free stage")
  `ASFS_ASSERT(a_compute_enters, rd_fire |=> v1_r, "accepted compute beat lost at stage one")
  `ASFS_ASSERT(a_load_silent, (in_fire && !is_compute) |=> !v1_r, "load beat in result path")

endmodule

// ----- tb/tb_anisotropic_stress_from_strain_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anisotropic_stress_from_strain_unit
// Streams coefficient loads and stress computes through the unit with bursty
// input and a stalling output. A local copy of the stiffness store predicts
// every stress beat, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_anisotropic_stress_from_strain_unit;

  localparam int  DATA_W        = asfs_pkg::DATA_W;
  localparam int  POINT_W       = asfs_pkg::POINT_W;
  localparam int  SLOT_W        = asfs_pkg::SLOT_W;
  localparam int  NUM_ROWS      = asfs_pkg::NUM_ROWS;
  localparam int  NUM_SLOTS     = asfs_pkg::NUM_SLOTS;
  localparam int  SUM_W         = asfs_pkg::SUM_W;
  localparam int  FRAC_BITS     = asfs_pkg::FRAC_BITS;

  typedef asfs_pkg::word_t word_t;

  localparam int  NPTS          = asfs_pkg::NUM_POINTS_DEF;
  localparam int  RANDOM_BEATS  = 1700;
  localparam int  DRAIN_CYCLES  = 20;
  localparam word_t ONE_Q       = 32'sh0100_0000;
  localparam word_t WORD_MAX    = 32'sh7fff_ffff;
  localparam word_t WORD_MIN    = 32'sh8000_0000;
  localparam logic signed [SUM_W+2:0] STRESS_MAX = (SUM_W+3)'(WORD_MAX);
  localparam logic signed [SUM_W+2:0] STRESS_MIN = (SUM_W+3)'(WORD_MIN);

  typedef struct packed {
    asfs_pkg::action_t           action;
    logic [POINT_W-1:0]          point;
    logic [SLOT_W-1:0]           slot;
    logic [DATA_W-1:0]           value;
    logic [NUM_ROWS-1:0][DATA_W-1:0] strain;
  } stiff_beat_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0][DATA_W-1:0] stress;
    logic                        saturated;
  } stress_beat_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_FLICKER,
    RX_BLOCKS
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  stiff_beat_t in_beat = '0;
  logic in_ready;
  logic out_valid;
  logic out_saturated;
  word_t out_stress [NUM_ROWS];

  stiff_beat_t  pending_beats [$];
  stress_beat_t expected_stress [$];
  word_t        stiffness_copy [NPTS][NUM_SLOTS];

  // generator bookkeeping: which slots of each point hold a coefficient
  logic [NUM_SLOTS-1:0] loaded_slots [NPTS];
  int ready_points [$];

  int gap_left = 0;
  int burst_left = 0;
  int beats_accepted = 0;
  int stress_checked = 0;
  int clipped_seen = 0;
  int mismatch_count = 0;
  rx_mode_t rx_mode = RX_FREE;
  int rx_hold = 0;
  int rx_cycle = 0;

  always #5 clk = ~clk;

  anisotropic_stress_from_strain_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_beat.action),
    .in_point           (in_beat.point),
    .in_coeff_slot      (in_beat.slot),
    .in_coeff_value     (in_beat.value),
    .in_strain_voigt_1  (in_beat.strain[0]),
    .in_strain_voigt_2  (in_beat.strain[1]),
    .in_strain_voigt_3  (in_beat.strain[2]),
    .in_strain_voigt_4  (in_beat.strain[3]),
    .in_strain_voigt_5  (in_beat.strain[4]),
    .in_strain_voigt_6  (in_beat.strain[5]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_stress_voigt_1 (out_stress[0]),
    .out_stress_voigt_2 (out_stress[1]),
    .out_stress_voigt_3 (out_stress[2]),
    .out_stress_voigt_4 (out_stress[3]),
    .out_stress_voigt_5 (out_stress[4]),
    .out_stress_voigt_6 (out_stress[5]),
    .out_saturated      (out_saturated)
  );

  // sigma_i = sum_j C_ij * eps_j, summed exactly, floored by the fraction
  // shift and clipped to 32 bits
  function automatic stress_beat_t hooke_stress(input stiff_beat_t b);
    stress_beat_t res;
    logic signed [SUM_W+2:0] acc;
    logic signed [SUM_W+2:0] scaled;
    word_t cf;
    word_t ep;
    int i;
    int j;
    int lo;
    int hi;
    res = '0;
    for (i = 0; i < NUM_ROWS; i++) begin
      acc = '0;
      for (j = 0; j < NUM_ROWS; j++) begin
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        // upper-triangle row-major index of C(lo, hi)
        cf = stiffness_copy[b.point][lo * NUM_ROWS - lo * (lo - 1) / 2 + hi - lo];
        ep = b.strain[j];
        acc = acc + cf * ep;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > STRESS_MAX) begin
        res.stress[i] = WORD_MAX;
        res.saturated = 1'b1;
      end else if (scaled < STRESS_MIN) begin
        res.stress[i] = WORD_MIN;
        res.saturated = 1'b1;
      end else begin
        res.stress[i] = scaled[DATA_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic absorb_beat(input stiff_beat_t b);
    if (b.action == asfs_pkg::ACT_COMPUTE) begin
      expected_stress.push_back(hooke_stress(b));
    end else if (b.slot < NUM_SLOTS) begin
      stiffness_copy[b.point][b.slot] = b.value;
    end
  endtask

  // wide spread of magnitudes: full range down to a few LSBs, either sign
  function automatic word_t rand_word();
    word_t w;
    w = $urandom;
    return w >>> $urandom_range(0, 31);
  endfunction

  function automatic stiff_beat_t junk_beat();
    stiff_beat_t b;
    int k;
    b.action = asfs_pkg::ACT_LOAD;
    b.point  = POINT_W'($urandom);
    b.slot   = SLOT_W'($urandom);
    b.value  = $urandom;
    for (k = 0; k < NUM_ROWS; k++) b.strain[k] = $urandom;
    return b;
  endfunction

  task automatic push_load(input int p, input int s, input word_t v);
    stiff_beat_t b;
    b = junk_beat();
    b.point = POINT_W'(p);
    b.slot  = SLOT_W'(s);
    b.value = v;
    pending_beats.push_back(b);
    if (s < NUM_SLOTS && !(&loaded_slots[p])) begin
      loaded_slots[p][s] = 1'b1;
      if (&loaded_slots[p]) ready_points.push_back(p);
    end
  endtask

  task automatic push_compute(input int p, input logic [NUM_ROWS-1:0][DATA_W-1:0] eps);
    stiff_beat_t b;
    b = junk_beat();
    b.action = asfs_pkg::ACT_COMPUTE;
    b.point  = POINT_W'(p);
    b.strain = eps;
    pending_beats.push_back(b);
  endtask

  // all 21 coefficients in shuffled order, now and then an ignored slot
  task automatic fill_point(input int p);
    int order [NUM_SLOTS];
    int k;
    int r;
    int t;
    for (k = 0; k < NUM_SLOTS; k++) order[k] = k;
    for (k = NUM_SLOTS - 1; k > 0; k--) begin
      r = $urandom_range(0, k);
      t = order[k];
      order[k] = order[r];
      order[r] = t;
    end
    for (k = 0; k < NUM_SLOTS; k++) begin
      if ($urandom_range(0, 15) == 0) push_load(p, $urandom_range(NUM_SLOTS, 31), rand_word());
      push_load(p, order[k], rand_word());
    end
  endtask

  function automatic logic [NUM_ROWS-1:0][DATA_W-1:0] rand_strains();
    logic [NUM_ROWS-1:0][DATA_W-1:0] eps;
    int k;
    for (k = 0; k < NUM_ROWS; k++) begin
      case ($urandom_range(0, 9))
        0:       eps[k] = '0;
        1:       eps[k] = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        default: eps[k] = rand_word();
      endcase
    end
    return eps;
  endfunction

  task automatic build_stimulus();
    logic [NUM_ROWS-1:0][DATA_W-1:0] eps;
    int k;
    int p;
    int pick;
    for (k = 0; k < NPTS; k++) loaded_slots[k] = '0;

    // directed: top point with extreme and unit coefficients
    for (k = 0; k < NUM_SLOTS; k++) begin
      case (k)
        0:              push_load(NPTS - 1, k, WORD_MAX);
        20:             push_load(NPTS - 1, k, WORD_MIN);
        6, 11, 15, 18:  push_load(NPTS - 1, k, ONE_Q);
        1:              push_load(NPTS - 1, k, -ONE_Q);
        default:        push_load(NPTS - 1, k, 32'sh0080_0000);
      endcase
    end
    push_compute(NPTS - 1, '0);
    push_compute(NPTS - 1, {NUM_ROWS{WORD_MAX}});
    push_compute(NPTS - 1, {NUM_ROWS{WORD_MIN}});
    eps = '0;
    eps[0] = ONE_Q;
    push_compute(NPTS - 1, eps);
    // one LSB below zero everywhere: floor rounding
    push_compute(NPTS - 1, {NUM_ROWS{32'hffff_ffff}});
    // out-of-range slots must leave the store alone
    push_load(NPTS - 1, NUM_SLOTS, 32'sh0);
    push_load(NPTS - 1, 31, 32'sh0);
    push_compute(NPTS - 1, {NUM_ROWS{WORD_MAX}});

    fill_point(0);
    while (pending_beats.size() < RANDOM_BEATS + 30) begin
      pick = $urandom_range(0, 99);
      if (pick < 3 && ready_points.size() < NPTS) begin
        do p = $urandom_range(0, NPTS - 1); while (&loaded_slots[p]);
        fill_point(p);
      end else if (pick < 72) begin
        push_compute(ready_points[$urandom_range(0, ready_points.size() - 1)],
                     rand_strains());
      end else if (pick < 88) begin
        push_load(ready_points[$urandom_range(0, ready_points.size() - 1)],
                  $urandom_range(0, NUM_SLOTS - 1), rand_word());
      end else if (pick < 94) begin
        push_load($urandom_range(0, NPTS - 1), $urandom_range(NUM_SLOTS, 31), rand_word());
      end else begin
        // partial load of a point not yet complete
        p = $urandom_range(0, NPTS - 1);
        if (!(&loaded_slots[p])) push_load(p, $urandom_range(0, NUM_SLOTS - 1), rand_word());
      end
    end
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    logic next_valid;
    stiff_beat_t next_beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_beat  = in_beat;
      if (in_valid && in_ready) begin
        absorb_beat(in_beat);
        beats_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          next_beat  = pending_beats.pop_front();
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= next_valid;
      in_beat  <= next_beat;
    end
  end

  task automatic check_stress();
    stress_beat_t got;
    stress_beat_t want;
    int k;
    logic bad;
    for (k = 0; k < NUM_ROWS; k++) got.stress[k] = out_stress[k];
    got.saturated = out_saturated;
    if (expected_stress.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected stress beat at %0t", $realtime);
      return;
    end
    want = expected_stress.pop_front();
    stress_checked++;
    if (got.saturated) clipped_seen++;
    bad = (got.saturated !== want.saturated);
    for (k = 0; k < NUM_ROWS; k++) bad |= (got.stress[k] !== want.stress[k]);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("stress mismatch at %0t (beat %0d):", $realtime, stress_checked);
        for (k = 0; k < NUM_ROWS; k++) begin
          $display("  sigma%0d expected %0d got %0d", k + 1,
                   $signed(want.stress[k]), $signed(got.stress[k]));
        end
        $display("  clip expected %0b got %0b", want.saturated, got.saturated);
      end
    end
  endtask

  // receiver: out_ready follows a randomly redrawn mode
  always @(posedge clk) begin
    logic next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_stress();
      if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_cycle++;
      case (rx_mode)
        RX_FREE:    next_ready = 1'b1;
        RX_FLICKER: next_ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            next_ready = 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_hold    = $urandom_range(1, 12);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
      out_ready <= next_ready;
    end
  end

  initial begin
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_beats.size() != 0 || in_valid || expected_stress.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d input beats accepted, %0d stress beats checked (%0d clipped)",
             beats_accepted, stress_checked, clipped_seen);
    $display("%0d grid points fully loaded, %0d mismatches",
             ready_points.size(), mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d stress beats still awaited", expected_stress.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
